/* src/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        flush;
  } u16u8_in_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] byte_count;
    logic       illegal_sequence;
  } u16u8_out_t;

  // Command kinds passed from the classifier to the encoder
  localparam logic [1:0] KIND_NONE = 2'd0;  // no bytes, no error
  localparam logic [1:0] KIND_ENC  = 2'd1;  // encode cp
  localparam logic [1:0] KIND_BAD  = 2'd2;  // broken surrogate pairing

  localparam int unsigned CP_W = 21;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CP_W-1:0] cp;
  } u16u8_cmd_t;

  localparam logic [5:0]      LEAD_TAG   = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]      TRAIL_TAG  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;
  localparam logic [CP_W-1:0] LIM_ONE    = 21'h000080;
  localparam logic [CP_W-1:0] LIM_TWO    = 21'h000800;
  localparam logic [CP_W-1:0] LIM_THREE  = 21'h010000;

endpackage

/* src/utf16_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of UTF-16 code units into UTF-8 byte groups.
//
// Input channel in_valid/in_stall/in_data carries one code unit (or a flush)
// per transfer; output channel out_valid/out_stall/out_data returns exactly
// one result per input: up to four bytes, a count and an error flag.
// A high surrogate gives a zero-byte result and is held until the next unit.
// Each transfer is queued, then encoded into the output register (out_valid);
// one item per cycle passes the classifier and encoder while out_stall is low.
// The command queue (QUEUE_DEPTH entries) decouples the classifier from the
// encoder; in_stall rises only when it is full, so the input keeps flowing
// while a finished result waits in the output register.
// When out_stall is held, the output holds its result and the queue fills,
// then in_stall is raised. Reset empties the queue, drops out_valid and
// clears the held surrogate.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u16u8_pkg::u16u8_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16u8_pkg::u16u8_out_t out_data
);
  import u16u8_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  u16u8_cmd_t push_cmd;
  u16u8_cmd_t q_cmd;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_cmd (push_cmd)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* src/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a waiting high surrogate and turns each unit
// into a command for the encoder.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  u16u8_pkg::u16u8_in_t  in_data,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  push,
  output u16u8_pkg::u16u8_cmd_t push_cmd
);
  import u16u8_pkg::*;

  logic       lead_pending_r;
  logic       lead_pending_nxt;
  logic [9:0] lead_low_bits_r;
  logic [9:0] lead_low_bits_nxt;
  logic       is_lead;
  logic       is_trail;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign is_lead  = (in_data.code_unit[15:10] == LEAD_TAG);
  assign is_trail = (in_data.code_unit[15:10] == TRAIL_TAG);

  always_comb begin
    lead_pending_nxt  = lead_pending_r;
    lead_low_bits_nxt = lead_low_bits_r;
    push_cmd.kind     = KIND_NONE;
    push_cmd.cp       = '0;
    priority if (in_data.flush) begin
      lead_pending_nxt  = 1'b0;
      lead_low_bits_nxt = '0;
    end else if (lead_pending_r) begin
      if (is_trail) begin
        push_cmd.kind = KIND_ENC;
        push_cmd.cp   = SUPP_BASE + {1'b0, lead_low_bits_r, in_data.code_unit[9:0]};
      end else begin
        push_cmd.kind = KIND_BAD;
      end
      lead_pending_nxt  = 1'b0;
      lead_low_bits_nxt = '0;
    end else if (is_lead) begin
      lead_pending_nxt  = 1'b1;
      lead_low_bits_nxt = in_data.code_unit[9:0];
    end else if (is_trail) begin
      push_cmd.kind = KIND_BAD;
    end else begin
      push_cmd.kind = KIND_ENC;
      push_cmd.cp   = {5'd0, in_data.code_unit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r  <= 1'b0;
      lead_low_bits_r <= '0;
    end else if (push) begin
      lead_pending_r  <= lead_pending_nxt;
      lead_low_bits_r <= lead_low_bits_nxt;
    end
  end

endmodule

/* src/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// Short command queue between classifier and encoder.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::u16u8_cmd_t push_cmd,
  input  logic                  pop,
  output logic                  full,
  output logic                  q_valid,
  output u16u8_pkg::u16u8_cmd_t q_cmd
);
  import u16u8_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u16u8_cmd_t    entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// Encodes queued commands as UTF-8 bytes into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  u16u8_pkg::u16u8_cmd_t q_cmd,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output u16u8_pkg::u16u8_out_t out_data
);
  import u16u8_pkg::*;

  logic       out_valid_r;
  logic       out_valid_nxt;
  u16u8_out_t out_data_r;
  u16u8_out_t enc;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    enc = '0;
    unique case (q_cmd.kind)
      KIND_ENC: begin
        priority if (q_cmd.cp < LIM_ONE) begin
          enc.byte0      = {1'b0, q_cmd.cp[6:0]};
          enc.byte_count = 3'd1;
        end else if (q_cmd.cp < LIM_TWO) begin
          enc.byte0      = {3'b110, q_cmd.cp[10:6]};
          enc.byte1      = {2'b10, q_cmd.cp[5:0]};
          enc.byte_count = 3'd2;
        end else if (q_cmd.cp < LIM_THREE) begin
          enc.byte0      = {4'b1110, q_cmd.cp[15:12]};
          enc.byte1      = {2'b10, q_cmd.cp[11:6]};
          enc.byte2      = {2'b10, q_cmd.cp[5:0]};
          enc.byte_count = 3'd3;
        end else begin
          enc.byte0      = {5'b11110, q_cmd.cp[20:18]};
          enc.byte1      = {2'b10, q_cmd.cp[17:12]};
          enc.byte2      = {2'b10, q_cmd.cp[11:6]};
          enc.byte3      = {2'b10, q_cmd.cp[5:0]};
          enc.byte_count = 3'd4;
        end
      end
      KIND_BAD: begin
        enc.illegal_sequence = 1'b1;
      end
      default: begin
        enc = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= enc;
    end
  end

endmodule

/* src/u16u8_checker.sv */
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input u16u8_pkg::u16u8_out_t out_data
);
  import u16u8_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.byte_count <= 3'd4)
    else $error("byte count out of range");

  a_error_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.illegal_sequence |->
      out_data.byte_count == 3'd0 && out_data.byte0 == 8'd0)
    else $error("error result carries bytes");

  a_four_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_count == 3'd4 |->
      out_data.byte0[7:3] == 5'b11110 && out_data.byte3[7:6] == 2'b10)
    else $error("malformed four-byte sequence");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
